@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the smoother's pass cell.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked on clk outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

@@ rtl/core/cps_pkg.sv @@
// Shared types, constants and the corner-cut arithmetic of the path smoother.
`timescale 1ns / 1ps
package cps_pkg;

  localparam int MAX_LEVELS  = 5;
  localparam int COORD_WIDTH = 16;
  localparam int LEVEL_W     = 3;
  localparam int SUM_W       = COORD_WIDTH + 2;
  localparam int TDATA_W     = 2 * COORD_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // One path point as it moves between passes
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pt_t;

  localparam logic signed [SUM_W-1:0] Q_HI = SUM_W'(2 ** (COORD_WIDTH - 1) - 1);
  localparam logic signed [SUM_W-1:0] Q_LO = SUM_W'(-(2 ** (COORD_WIDTH - 1)));

  // round((3a + b) / 4), halves away from zero, clamped to the coordinate range.
  // Negative sums use floor((s + 1) / 4), positive ones floor((s + 2) / 4).
  function automatic coord_t cut(coord_t a, coord_t b);
    logic signed [SUM_W-1:0] ae;
    logic signed [SUM_W-1:0] be;
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] q;
    coord_t res;
    ae = {{2{a[COORD_WIDTH-1]}}, a};
    be = {{2{b[COORD_WIDTH-1]}}, b};
    s  = (ae <<< 1) + ae + be;
    t  = s + (s[SUM_W-1] ? SUM_W'(1) : SUM_W'(2));
    q  = {{2{t[SUM_W-1]}}, t[SUM_W-1:2]};
    if (q > Q_HI) begin
      res = Q_HI[COORD_WIDTH-1:0];
    end else if (q < Q_LO) begin
      res = Q_LO[COORD_WIDTH-1:0];
    end else begin
      res = q[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/cps_cell.sv @@
// One Chaikin pass: takes a point stream, emits one to three points per request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cps_cell import cps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,          // pass active; when low points go straight through
  input  pt_t  in_pt,
  input  logic in_valid,
  output logic in_ready,
  output pt_t  out_pt,
  output logic out_valid,
  input  logic out_ready
);

  typedef enum logic [1:0] {STEP_0, STEP_1, STEP_2} step_t;

  logic   busy_r;
  step_t  step_r;
  logic   have_prev_r;
  coord_t prev_x_r;
  coord_t prev_y_r;
  pt_t    cur_r;
  pt_t    out_r;
  logic   out_valid_r;

  step_t  last_step;
  pt_t    emit;
  logic   load;
  logic   final_step;
  logic   take;

  // Number of points this request produces, as the index of the final one
  always_comb begin
    if (!en) begin
      last_step = STEP_0;
    end else if (!have_prev_r) begin
      last_step = cur_r.last ? STEP_1 : STEP_0;
    end else begin
      last_step = cur_r.last ? STEP_2 : STEP_1;
    end
  end

  // Point emitted at the current step
  always_comb begin
    emit = cur_r;
    if (!en) begin
      emit = cur_r;
    end else if (!have_prev_r) begin
      emit.last = (step_r == STEP_1);
    end else begin
      case (step_r)
        STEP_0: begin
          emit.x    = cut(prev_x_r, cur_r.x);
          emit.y    = cut(prev_y_r, cur_r.y);
          emit.last = 1'b0;
        end
        STEP_1: begin
          emit.x    = cut(cur_r.x, prev_x_r);
          emit.y    = cut(cur_r.y, prev_y_r);
          emit.last = 1'b0;
        end
        default: begin
          emit = cur_r;
        end
      endcase
    end
  end

  assign load       = busy_r && (!out_valid_r || out_ready);
  assign final_step = (step_r == last_step);
  assign in_ready   = !busy_r || (load && final_step);
  assign take       = in_valid && in_ready;

  // Control: sequencing, open-path flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load && final_step) begin
        step_r <= STEP_0;
        busy_r <= 1'b0;
        if (en) begin
          have_prev_r <= !cur_r.last;
        end
      end else if (load) begin
        step_r <= step_t'(step_r + 2'd1);
      end
      if (take) begin
        busy_r <= 1'b1;
      end
    end
  end

  // Payload: current point, previous point, output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= emit;
    end
    if (load && final_step && en) begin
      prev_x_r <= cur_r.x;
      prev_y_r <= cur_r.y;
    end
    if (take) begin
      cur_r <= in_pt;
    end
  end

  assign out_pt    = out_r;
  assign out_valid = out_valid_r;

  `ASSERT_IMPL(a_step_bound, busy_r, step_r <= last_step)
  `ASSERT_IMPL(a_idle_step, !busy_r, step_r == STEP_0)
  `ASSERT_IMPL(a_last_final, load && emit.last, final_step)
  `ASSERT_NEXT(a_close_path, load && final_step && en && cur_r.last, !have_prev_r)
  `ASSERT_IMPL(a_ready_busy, in_ready && busy_r, load && final_step)

endmodule

@@ rtl/core/chaikin_path_smoother_core.sv @@
// Top level: level register and the row of Chaikin pass cells.
//
// Usage: points enter on the in_ stream (x, y packed in in_tdata, end of
// path on in_tlast) and leave on the out_ stream in the same format. The
// cfg_ port sets the number of passes (0..5, larger values act as 5); write
// it only while the block is empty. The row holds five cells, one per pass;
// unused passes forward points untouched and keep their state.
// Each cell passes a point through a point register, then an output
// register, on its way to the next cell.
// Throughput: each active pass emits one point per cycle unless its output
// stalls, and doubles the stream: a middle point becomes 2^levels points
// at the output (32 at five passes), the final point of a path 2^(levels+1)-1.
// The last cell's output register sets the pace; each cell takes its next
// point in the cycle its final result leaves.
// Reset (synchronous, rst_n low) empties every cell, closes all open paths
// and sets the pass count to zero. When the receiver stalls, out_tdata holds
// and back-pressure ripples up the row to in_tready; nothing is dropped.
`timescale 1ns / 1ps
module chaikin_path_smoother_core import cps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LEVEL_W-1:0] cfg_wr_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // x [15:0], y [31:16]
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // x [15:0], y [31:16]
  output logic               out_tlast
);

  level_t levels_r;
  level_t lv;
  pt_t    link_pt    [MAX_LEVELS+1];
  logic   link_valid [MAX_LEVELS+1];
  logic   link_ready [MAX_LEVELS+1];

  // Pass count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
    end else if (cfg_wr_en) begin
      levels_r <= cfg_wr_data;
    end
  end

  assign lv = (levels_r > level_t'(MAX_LEVELS)) ? level_t'(MAX_LEVELS) : levels_r;

  // Input side of the row
  assign link_pt[0].x    = in_tdata[COORD_WIDTH-1:0];
  assign link_pt[0].y    = in_tdata[TDATA_W-1:COORD_WIDTH];
  assign link_pt[0].last = in_tlast;
  assign link_valid[0]   = in_tvalid;
  assign in_tready       = link_ready[0];

  // Row of pass cells
  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    cps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (level_t'(k) < lv),
      .in_pt    (link_pt[k]),
      .in_valid (link_valid[k]),
      .in_ready (link_ready[k]),
      .out_pt   (link_pt[k+1]),
      .out_valid(link_valid[k+1]),
      .out_ready(link_ready[k+1])
    );
  end

  // Output side of the row
  assign out_tvalid             = link_valid[MAX_LEVELS];
  assign link_ready[MAX_LEVELS] = out_tready;
  assign out_tdata              = {link_pt[MAX_LEVELS].y, link_pt[MAX_LEVELS].x};
  assign out_tlast              = link_pt[MAX_LEVELS].last;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Chaikin path smoother core.
`timescale 1ns / 1ps
module tb import cps_pkg::*; ();

  localparam int C_MAX         = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int C_MIN         = -(2 ** (COORD_WIDTH - 1));
  localparam int SETTLE_CYCLES = 10;    // row depth plus margin
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake
  localparam int ITEM_TARGET   = 450;   // directed plus random points, reached at the end of a phase

  typedef enum int {SPREAD_FULL, SPREAD_WALK, SPREAD_EDGE, SPREAD_TINY} spread_t;

  // Corner-cut predictor and store of smoothed points still owed by the block
  class corner_cut_board_t;
    coord_t      held_x[MAX_LEVELS];
    coord_t      held_y[MAX_LEVELS];
    bit          path_open[MAX_LEVELS];
    int unsigned passes;
    pt_t         smoothed_pts[$];
    int unsigned errors;

    function void set_levels(level_t v);
      passes = (v > MAX_LEVELS) ? MAX_LEVELS : v;
    endfunction

    function int unsigned pending();
      return smoothed_pts.size();
    endfunction

    // round((3a + b) / 4), halves away from zero, clamped
    function coord_t cut_corner(coord_t a, coord_t b);
      int s;
      int q;
      s = 3 * int'(a) + int'(b);
      if (s >= 0) q = (s + 2) / 4;
      else q = -((2 - s) / 4);
      if (q > C_MAX) q = C_MAX;
      else if (q < C_MIN) q = C_MIN;
      return coord_t'(q);
    endfunction

    // Run one accepted request through the active passes
    function void accept_point(pt_t p);
      pt_t cur[$];
      pt_t nxt[$];
      pt_t o;
      int  k;
      cur = {cur, p};
      for (k = 0; k < passes; k++) begin
        nxt.delete();
        foreach (cur[i]) begin
          if (!path_open[k]) begin
            // path start: point goes out as is
            o = cur[i];
            o.last = 1'b0;
            nxt = {nxt, o};
            if (cur[i].last) begin
              nxt = {nxt, cur[i]};
            end else begin
              held_x[k] = cur[i].x;
              held_y[k] = cur[i].y;
              path_open[k] = 1'b1;
            end
          end else begin
            o.last = 1'b0;
            o.x = cut_corner(held_x[k], cur[i].x);
            o.y = cut_corner(held_y[k], cur[i].y);
            nxt = {nxt, o};
            o.x = cut_corner(cur[i].x, held_x[k]);
            o.y = cut_corner(cur[i].y, held_y[k]);
            nxt = {nxt, o};
            held_x[k] = cur[i].x;
            held_y[k] = cur[i].y;
            if (cur[i].last) begin
              nxt = {nxt, cur[i]};
              path_open[k] = 1'b0;
            end
          end
        end
        cur = nxt;
      end
      smoothed_pts = {smoothed_pts, cur};
    endfunction

    function void check_point(pt_t got);
      pt_t want;
      if (smoothed_pts.size() == 0) begin
        if (errors < 10)
          $display("tb: unexpected result x=%0d y=%0d last=%0b", got.x, got.y, got.last);
        errors++;
      end else begin
        want = smoothed_pts.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
          if (errors < 10)
            $display("tb: mismatch got x=%0d y=%0d last=%0b, want x=%0d y=%0d last=%0b",
                     got.x, got.y, got.last, want.x, want.y, want.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  level_t             cfg_wr_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;   // x [15:0], y [31:16]
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;  // x [15:0], y [31:16]
  logic               out_tlast;

  corner_cut_board_t board = new();
  bit tx_steady;
  bit rx_steady;
  int hold_off_req = 0;   // count of long hold-offs asked for
  int items_sent;
  int quiet_cycles = 0;

  chaikin_path_smoother_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: note requests, check results, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.accept_point('{x: coord_t'(in_tdata[15:0]), y: coord_t'(in_tdata[31:16]),
                             last: in_tlast});
      if (out_tvalid && out_tready)
        board.check_point('{x: coord_t'(out_tdata[15:0]), y: coord_t'(out_tdata[31:16]),
                            last: out_tlast});
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, steady stretches, one long hold-off on request
  initial begin
    int gap;
    int hold_off_done;
    hold_off_done = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_off_req != hold_off_done) begin
        gap = HOLD_CYCLES;
        hold_off_done = hold_off_req;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_point(int x, int y, bit last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {coord_t'(y), coord_t'(x)};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop offering and let every owed result come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_levels(level_t v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_levels(v);
  endtask

  function automatic int pick_coord(spread_t spread, int base);
    int v;
    case (spread)
      SPREAD_FULL: v = int'(coord_t'($urandom));
      SPREAD_WALK: v = base + int'($urandom_range(0, 200)) - 100;
      SPREAD_EDGE: begin
        case ($urandom_range(0, 4))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = int'($urandom_range(0, 16)) - 8;
    endcase
    if (v > C_MAX) v = C_MAX;
    else if (v < C_MIN) v = C_MIN;
    return v;
  endfunction

  // Stimulus
  initial begin
    int      phase;
    int      npaths;
    int      len;
    int      px;
    int      py;
    bit      close_path;
    spread_t spread;

    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    items_sent  = 0;
    board.set_levels('0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero passes after reset: straight through
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b1);

    // one pass: one-point path, extremes, rounding of halves both signs
    write_levels(3'd1);
    send_point(100, -100, 1'b1);
    send_point(C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(2, -2, 1'b0);
    send_point(-1, 1, 1'b0);
    send_point(1, -1, 1'b1);

    // five passes: largest expansion, then leave a path open in every pass
    write_levels(3'd5);
    send_point(-5, 7, 1'b0);
    send_point(9, -3, 1'b0);
    send_point(1000, -1000, 1'b1);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0);

    // fewer passes mid-path: upper passes keep their open path
    write_levels(3'd2);
    send_point(3, 3, 1'b0);
    send_point(-7, -1, 1'b1);

    // settings above the pass count saturate and resume the held paths
    write_levels(3'd7);
    send_point(11, -13, 1'b1);
    write_levels(3'd6);
    send_point(0, 0, 1'b1);

    // random phases of well-formed paths, some left open across a setting change
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      write_levels(phase == 0 ? 3'd3 : level_t'($urandom_range(0, 7)));
      tx_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
      rx_steady = (phase != 0) && ($urandom_range(0, 3) == 0);
      if (phase == 0 || $urandom_range(0, 9) == 0) begin
        tx_steady = 1'b1;
        hold_off_req++;
      end
      npaths = (phase == 0) ? 5 : $urandom_range(1, 5);
      for (int p = 0; p < npaths; p++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        spread = spread_t'($urandom_range(0, 3));
        close_path = (p != npaths - 1) || ($urandom_range(0, 3) != 0);
        px = int'(coord_t'($urandom));
        py = int'(coord_t'($urandom));
        for (int i = 0; i < len; i++) begin
          px = pick_coord(spread, px);
          py = pick_coord(spread, py);
          send_point(px, py, close_path && (i == len - 1));
        end
        // occasional pause until the block has caught up
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cps_pkg.sv
rtl/core/cps_cell.sv
rtl/core/chaikin_path_smoother_core.sv
tb/tb.sv
